// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

    localparam int HEAP_DEPTH_DEF    = 64;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int TIME_BITS_DEF     = 16;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int STAT_W  = 3;
    localparam int OUT_T_W = 16;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd0;
    localparam logic [STAT_W-1:0] ST_DROP   = 3'd1;
    localparam logic [STAT_W-1:0] ST_IDLE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_RAN    = 3'd3;
    localparam logic [STAT_W-1:0] ST_DONE   = 3'd4;

    // Heap memory port commands, sequencer to memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ===== rtl/core/pps_heap_mem.sv =====
module pps_heap_mem #(
    parameter int DEPTH  = pps_pkg::HEAP_DEPTH_DEF,
    parameter int WIDTH  = 8,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  pps_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler on a binary min-heap (lower priority value wins).
// Input stream s_axis: one item per command. tuser = operation (0 arrive,
// 1 tick); tdata = process_id, priority_req, burst_time from bit 0 up.
// Output stream m_axis: exactly one result item per input item.
// An arrive stamps the entry with the current time and sifts it up the heap;
// a full heap drops it. A tick pops the root, records first response, runs it
// one time unit and reinserts it if work remains, then advances the time.
// The heap lives in one synchronous memory (one read, one write per cycle);
// all six entry fields are kept in one wide word.
// One item is in work at a time; the next item is taken only after the receiver
// takes the result and the state returns to idle. A stalled receiver holds the
// result in the output register and s_axis_tready stays low until it is taken.
// Reset (synchronous, active low) empties the heap and clears time to zero;
// memory contents need no clearing since the fill count guards every read.
module preemptive_priority_scheduler #(
    parameter int HEAP_DEPTH    = pps_pkg::HEAP_DEPTH_DEF,
    parameter int PRIORITY_BITS = pps_pkg::PRIORITY_BITS_DEF,
    parameter int TIME_BITS     = pps_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // process_id[7:0], priority_req[15:8], burst_time[31:16]
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata   // status[2:0], run_id[10:3], run_time[26:11],
                                       // finish_time[42:27], response_time[58:43],
                                       // entry_time[74:59], zero pad [87:75]
);

    localparam int AW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int XW  = AW + 2;
    localparam int PW  = PRIORITY_BITS;
    localparam int TW  = TIME_BITS;
    localparam int IW  = pps_pkg::ID_W;
    localparam int RW  = pps_pkg::BURST_W;
    localparam int EW  = PW + IW + RW + TW + TW + 1;
    localparam int OW  = pps_pkg::OUT_T_W;

    typedef struct packed {
        logic [PW-1:0] prio;
        logic [IW-1:0] id;
        logic [RW-1:0] rem;
        logic [TW-1:0] ent;
        logic          rflag;
        logic [TW-1:0] resp;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_POP_RD0, S_POP_RDL, S_POP_GOT,
        S_DN_RDL, S_DN_RDR, S_DN_CMP, S_REINS, S_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [TW-1:0]   r_time;
    t_entry          r_cur;    // entry being moved (hole contents)
    logic [AW-1:0]   r_pos;
    t_entry          r_lch;
    t_entry          r_pop;    // popped entry waiting for reinsert
    logic            r_reins;
    logic [pps_pkg::STAT_W-1:0] r_stat;
    logic [IW-1:0]   r_oid;
    logic [OW-1:0]   r_orun, r_ofin, r_oresp, r_oent;
    logic            r_ovalid;

    pps_pkg::t_mem_ctl n_ctl;
    logic [AW-1:0]   n_rd_addr, n_wr_addr;
    t_entry          n_wr_data;
    logic [EW-1:0]   w_rd;
    t_entry          w_rde;

    assign w_rde = t_entry'(w_rd);

    pps_heap_mem #(.DEPTH(HEAP_DEPTH), .WIDTH(EW), .AW(AW)) u_mem (
        .i_clk    (i_clk),
        .i_ctl    (n_ctl),
        .i_rd_addr(n_rd_addr),
        .i_wr_addr(n_wr_addr),
        .i_wr_data(n_wr_data),
        .o_rd_data(w_rd)
    );

    // Child index helpers (wide enough to detect out of range).
    logic [AW:0] w_l, w_r, w_par;
    assign w_l   = {r_pos, 1'b1};
    assign w_r   = {r_pos, 1'b0} + {{AW{1'b0}}, 1'b1} + {{AW{1'b0}}, 1'b1};
    assign w_par = ({1'b0, r_pos} - {{AW{1'b0}}, 1'b1}) >> 1;

    logic w_l_in, w_r_in;
    assign w_l_in = (XW'(w_l) < XW'(r_count));
    assign w_r_in = (XW'(w_r) < XW'(r_count));

    // Sift-down choice: left when strictly smaller than the hole entry,
    // right when strictly smaller than the better of the two.
    logic [PW-1:0] w_min_lc;
    logic          w_pick_l, w_pick_r;
    assign w_min_lc = (r_lch.prio < r_cur.prio) ? r_lch.prio : r_cur.prio;
    assign w_pick_r = w_r_in && (w_rde.prio < w_min_lc);
    assign w_pick_l = !w_pick_r && (r_lch.prio < r_cur.prio);

    // Memory port drive
    always_comb begin
        n_ctl     = '0;
        n_rd_addr = r_pos;
        n_wr_addr = r_pos;
        n_wr_data = r_cur;
        unique case (r_state)
            S_UP_RD: begin
                n_ctl.rd_en = (r_pos != '0);
                n_rd_addr   = w_par[AW-1:0];
                n_ctl.wr_en = (r_pos == '0);
            end
            S_UP_CMP: begin
                // parent larger: move parent down into hole, else settle here
                n_ctl.wr_en = 1'b1;
                if (w_rde.prio > r_cur.prio) begin
                    n_wr_data = w_rde;
                end
            end
            S_POP_RD0: begin
                n_ctl.rd_en = 1'b1;
                n_rd_addr   = '0;
            end
            S_POP_RDL: begin
                n_ctl.rd_en = 1'b1;
                n_rd_addr   = AW'(r_count);
            end
            S_DN_RDL: begin
                n_ctl.rd_en = w_l_in;
                n_rd_addr   = w_l[AW-1:0];
                n_ctl.wr_en = !w_l_in;
            end
            S_DN_RDR: begin
                n_ctl.rd_en = w_r_in;
                n_rd_addr   = w_r[AW-1:0];
            end
            S_DN_CMP: begin
                // chosen child moves up into the hole, else the hole settles
                n_ctl.wr_en = 1'b1;
                if (w_pick_r) begin
                    n_wr_data = w_rde;
                end else if (w_pick_l) begin
                    n_wr_data = r_lch;
                end
            end
            default: ;
        endcase
    end

    t_entry        w_popped;
    always_comb begin
        w_popped = r_lch;
        if (!r_lch.rflag) begin
            w_popped.rflag = 1'b1;
            w_popped.resp  = r_time - r_lch.ent;
        end
        w_popped.rem = (r_lch.rem > RW'(1)) ? (r_lch.rem - RW'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_time   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_oid  <= '0;
                        r_orun <= '0;
                        r_ofin <= '0;
                        r_oresp <= '0;
                        r_oent <= '0;
                        if (s_axis_tuser == pps_pkg::OP_ARRIVE) begin
                            if (r_count >= CW'(HEAP_DEPTH)) begin
                                r_stat  <= pps_pkg::ST_DROP;
                                r_state <= S_OUT;
                            end else begin
                                r_stat      <= pps_pkg::ST_ACCEPT;
                                r_cur.prio  <= PW'(s_axis_tdata[15:8]);
                                r_cur.id    <= s_axis_tdata[7:0];
                                r_cur.rem   <= (s_axis_tdata[31:16] == '0) ? RW'(1)
                                                                         : s_axis_tdata[31:16];
                                r_cur.ent   <= r_time;
                                r_cur.rflag <= 1'b0;
                                r_cur.resp  <= '0;
                                r_pos       <= AW'(r_count);
                                r_count     <= r_count + CW'(1);
                                r_state     <= S_UP_RD;
                            end
                        end else if (r_count == '0) begin
                            r_stat  <= pps_pkg::ST_IDLE;
                            r_orun  <= OW'(r_time);
                            r_time  <= r_time + TW'(1);
                            r_state <= S_OUT;
                        end else begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_POP_RD0;
                        end
                    end
                end
                S_UP_RD: begin
                    r_state <= (r_pos == '0) ? S_OUT : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (w_rde.prio > r_cur.prio) begin
                        r_pos   <= w_par[AW-1:0];
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_POP_RD0: r_state <= S_POP_RDL;
                S_POP_RDL: begin
                    r_lch   <= w_rde; // root
                    r_state <= S_POP_GOT;
                end
                S_POP_GOT: begin
                    r_cur   <= w_rde; // last entry
                    r_pop   <= w_popped;
                    r_oid   <= r_lch.id;
                    r_orun  <= OW'(r_time);
                    r_oresp <= OW'(w_popped.resp);
                    r_oent  <= OW'(r_lch.ent);
                    r_reins <= (w_popped.rem != '0);
                    if (w_popped.rem == '0) begin
                        r_stat <= pps_pkg::ST_DONE;
                        r_ofin <= OW'(r_time + TW'(1));
                    end else begin
                        r_stat <= pps_pkg::ST_RAN;
                    end
                    r_time  <= r_time + TW'(1);
                    r_pos   <= '0;
                    r_state <= (r_count == '0) ? S_REINS : S_DN_RDL;
                end
                S_DN_RDL: begin
                    r_state <= w_l_in ? S_DN_RDR : S_REINS;
                end
                S_DN_RDR: begin
                    r_lch   <= w_rde; // left child
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (w_pick_r) begin
                        r_pos   <= w_r[AW-1:0];
                        r_state <= S_DN_RDL;
                    end else if (w_pick_l) begin
                        r_pos   <= w_l[AW-1:0];
                        r_state <= S_DN_RDL;
                    end else begin
                        r_state <= S_REINS;
                    end
                end
                S_REINS: begin
                    // a preempted process goes back at the end and climbs
                    if (r_reins) begin
                        r_cur   <= r_pop;
                        r_pos   <= AW'(r_count);
                        r_count <= r_count + CW'(1);
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                    end else if (m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {13'd0, r_oent, r_oresp, r_ofin, r_orun, r_oid, r_stat};

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEAP_DEPTH));

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid));
`endif

endmodule

// ===== bench/sched_checker.sv =====
module sched_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [87:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int DEPTH = pps_pkg::HEAP_DEPTH_DEF;

    typedef struct packed {
        logic [7:0]  prio;
        logic [7:0]  id;
        logic [15:0] rem;
        logic [15:0] ent;
        logic        seen;
        logic [15:0] resp;
    } t_slot;

    t_slot       heap [DEPTH];
    int          fill;
    logic [15:0] now;
    logic [87:0] expected_results [$];

    function automatic logic [87:0] pack_result(logic [2:0] st, logic [7:0] id,
            logic [15:0] rt, logic [15:0] ft, logic [15:0] rs, logic [15:0] et);
        return {13'd0, et, rs, ft, rt, id, st};
    endfunction

    task automatic push_slot(t_slot s);
        int   pos;
        int   up;
        t_slot t;
        pos = fill;
        heap[pos] = s;
        fill++;
        while (pos != 0) begin
            up = (pos - 1) / 2;
            if (!(heap[up].prio > heap[pos].prio)) break;
            t = heap[up]; heap[up] = heap[pos]; heap[pos] = t;
            pos = up;
        end
    endtask

    task automatic sift_root();
        int   pos;
        int   best;
        t_slot t;
        pos = 0;
        forever begin
            best = pos;
            if (2*pos+1 < fill && heap[2*pos+1].prio < heap[best].prio) best = 2*pos+1;
            if (2*pos+2 < fill && heap[2*pos+2].prio < heap[best].prio) best = 2*pos+2;
            if (best == pos) break;
            t = heap[best]; heap[best] = heap[pos]; heap[pos] = t;
            pos = best;
        end
    endtask

    task automatic predict_schedule(logic op, logic [31:0] d);
        t_slot s;
        if (op == pps_pkg::OP_ARRIVE) begin
            if (fill >= DEPTH) begin
                expected_results.push_back(pack_result(pps_pkg::ST_DROP,
                                                       '0, '0, '0, '0, '0));
            end else begin
                s.prio = d[15:8];
                s.id   = d[7:0];
                s.rem  = (d[31:16] == '0) ? 16'd1 : d[31:16];
                s.ent  = now;
                s.seen = 1'b0;
                s.resp = '0;
                push_slot(s);
                expected_results.push_back(pack_result(pps_pkg::ST_ACCEPT,
                                                       '0, '0, '0, '0, '0));
            end
            return;
        end
        if (fill == 0) begin
            expected_results.push_back(pack_result(pps_pkg::ST_IDLE, '0, now, '0, '0, '0));
        end else begin
            s = heap[0];
            if (!s.seen) begin
                s.seen = 1'b1;
                s.resp = now - s.ent;
            end
            fill--;
            if (fill >= 1) begin
                heap[0] = heap[fill];
                sift_root();
            end
            s.rem = s.rem - 16'd1;
            if (s.rem != '0) begin
                push_slot(s);
                expected_results.push_back(pack_result(pps_pkg::ST_RAN, s.id, now, '0,
                                                       s.resp, s.ent));
            end else begin
                expected_results.push_back(pack_result(pps_pkg::ST_DONE, s.id, now,
                                                       now + 16'd1, s.resp, s.ent));
            end
        end
        now = now + 16'd1;
    endtask

    always @(posedge i_clk) begin
        logic [87:0] e;
        if (!i_rst_n) begin
            fill = 0;
            now = 0;
            o_fail_count <= 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_schedule(i_in_user, i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e[2:0] !== i_out_data[2:0] || e[10:3] !== i_out_data[10:3]
                        || e[26:11] !== i_out_data[26:11] || e[42:27] !== i_out_data[42:27]
                        || e[58:43] !== i_out_data[58:43]
                        || e[74:59] !== i_out_data[74:59]) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_data = 0;   // process_id, priority_req, burst_time
    logic        s_user = 0;   // operation
    logic        m_valid;
    logic        m_ready = 0;
    logic [87:0] m_data;       // status, run_id, run_time, finish_time, response, entry
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 0;

    always #10 i_clk = ~i_clk;

    preemptive_priority_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    sched_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_in_user(s_user), .i_out_valid(m_valid), .i_out_ready(m_ready),
        .i_out_data(m_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one item, hold it until the handshake, then idle a random gap.
    task automatic send_item(logic op, logic [7:0] id, logic [7:0] pr,
                             logic [15:0] burst, bit no_gap);
        int g;
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {burst, pr, id};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    // Bursts are mostly short so processes finish and the heap churns.
    function automatic logic [15:0] rand_burst();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog: cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int n;
        int k;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick, extremes, zero burst, equal priorities, fill to drop.
        send_item(pps_pkg::OP_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        send_item(pps_pkg::OP_ARRIVE, 8'h00, 8'h00, 16'h0000, 1'b0);
        send_item(pps_pkg::OP_ARRIVE, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        send_item(pps_pkg::OP_ARRIVE, 8'h5A, 8'h10, 16'd2, 1'b0);
        send_item(pps_pkg::OP_ARRIVE, 8'hA5, 8'h10, 16'd2, 1'b0);
        send_item(pps_pkg::OP_ARRIVE, 8'h33, 8'h10, 16'd1, 1'b0);
        repeat (7) send_item(pps_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0);
        // Heap full: stalled receiver, back-to-back arrivals.
        hold_off = 1;
        for (k = 0; k < 66; k++)
            send_item(pps_pkg::OP_ARRIVE, k[7:0], 8'($urandom_range(0, 255)), 16'd1, 1'b1);
        for (k = 0; k < 70; k++) send_item(pps_pkg::OP_TICK, '0, '0, '0, k[0]);

        // Random: ticks and arrivals mixed at even odds.
        for (n = 0; n < 350; n++) begin
            if ($urandom_range(0, 1))
                send_item(pps_pkg::OP_ARRIVE, 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 7)),
                          rand_burst(), 1'b0);
            else
                send_item(pps_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)), 1'b0);
        end
        @(negedge i_clk);
        s_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
